@@ rtl/core/sibm_pkg.sv @@
// ----------------------------------------------------------------------------
// sibm_pkg: shared types and constants for the sparse index block map
// Holds widths, action and status codes, controller states and the
// command and status structs exchanged between controller and datapath.
// ----------------------------------------------------------------------------
package sibm_pkg;

    localparam int MAX_BLOCKS = 256;
    localparam int INDEX_BITS = 32;
    localparam int BLK_BITS   = $clog2(MAX_BLOCKS);
    localparam int CNT_BITS   = BLK_BITS + 1;

    typedef logic [INDEX_BITS-1:0] idx_t;
    typedef logic [BLK_BITS-1:0]   blk_t;
    typedef logic [CNT_BITS-1:0]   cnt_t;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_XLATE  = 2'd2,
        ACT_RANGE  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NOT_MAPPED = 3'd1,
        ST_FULL       = 3'd2,
        ST_BAD_RUN    = 3'd3,
        ST_RANGE_MT   = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_RD_HINT,
        S_CHK_HINT,
        S_CHK_NEXT,
        S_BS_RD,
        S_BS_CMP,
        S_FIN_RD,
        S_FIN_CHK,
        S_DONE
    } state_t;

    // Search target selection for the shared binary search.
    typedef enum logic [1:0] {
        TGT_X,
        TGT_LAST
    } target_t;

    typedef struct packed {
        logic    load;       // capture input beat
        logic    exec;       // clear / append / trivial decisions
        logic    rd_hint;    // read hint block (and predecessor)
        logic    chk_hint;   // evaluate hint block
        logic    chk_next;   // evaluate hint + 1 block
        logic    bs_init;    // start binary search
        logic    bs_rd;      // read midpoint
        logic    bs_cmp;     // compare midpoint
        logic    fin_rd;     // read found block
        logic    fin_chk;    // final check after search
        target_t tgt;
    } cmd_t;

    typedef struct packed {
        action_t act;
        logic    quick;      // result decided in exec step
        logic    hint_hit;
        logic    next_hit;
        logic    bs_done;
    } sts_t;

endpackage

@@ rtl/core/sibm_ctrl.sv @@
// ----------------------------------------------------------------------------
// sibm_ctrl: controller for the sparse index block map
// Sequences each action through table reads, the hint checks and the
// binary search, and drives the result handshake.
// ----------------------------------------------------------------------------
module sibm_ctrl
    import sibm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;
    logic   second_reg, second_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            second_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            second_reg <= second_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        second_next = second_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                second_next = 1'b0;
                if (in_valid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (sts.quick)
                    state_next = S_DONE;
                else if (sts.act == ACT_XLATE)
                    state_next = S_RD_HINT;
                else
                    state_next = S_BS_RD;
            end
            S_RD_HINT:  state_next = S_CHK_HINT;
            S_CHK_HINT: state_next = sts.hint_hit ? S_DONE : S_CHK_NEXT;
            S_CHK_NEXT: state_next = sts.next_hit ? S_DONE : S_BS_RD;
            S_BS_RD:    state_next = S_BS_CMP;
            S_BS_CMP:
            begin
                if (!sts.bs_done)
                    state_next = S_BS_RD;
                else if (sts.act == ACT_RANGE && !second_reg)
                begin
                    state_next  = S_BS_RD;
                    second_next = 1'b1;
                end
                else
                    state_next = S_FIN_RD;
            end
            S_FIN_RD:   state_next = S_FIN_CHK;
            S_FIN_CHK:  state_next = S_DONE;
            S_DONE:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        cmd.tgt   = second_reg ? TGT_LAST : TGT_X;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_EXEC:     cmd.exec = 1'b1;
            S_RD_HINT:  cmd.rd_hint = 1'b1;
            S_CHK_HINT: cmd.chk_hint = 1'b1;
            S_CHK_NEXT:
            begin
                cmd.chk_next = 1'b1;
                cmd.bs_init  = !sts.next_hit;
            end
            S_BS_RD:    cmd.bs_rd = 1'b1;
            S_BS_CMP:
            begin
                cmd.bs_cmp  = 1'b1;
                cmd.bs_init = sts.bs_done && sts.act == ACT_RANGE && !second_reg;
            end
            S_FIN_RD:   cmd.fin_rd = 1'b1;
            S_FIN_CHK:  cmd.fin_chk = 1'b1;
            S_DONE:     out_valid = 1'b1;
            default:    ;
        endcase
    end

endmodule

@@ rtl/core/sibm_dp.sv @@
// ----------------------------------------------------------------------------
// sibm_dp: datapath for the sparse index block map
// Holds the run table memory, the table bookkeeping registers, the binary
// search bounds and the result registers.
// ----------------------------------------------------------------------------
module sibm_dp
    import sibm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [1:0]  action,
    input  idx_t        logical_index,
    input  idx_t        run_length,
    input  idx_t        range_last,
    input  cmd_t        cmd,
    output sts_t        sts,
    output logic [2:0]  status,
    output logic [31:0] data_index,
    output logic [7:0]  block_index,
    output logic [7:0]  last_block_index
);

    // Each entry packs run start and cumulative end.
    logic [2*INDEX_BITS-1:0] mem [MAX_BLOCKS];

    action_t act_reg;
    idx_t    x_reg, len_reg, last_reg;

    cnt_t                count_reg;
    blk_t                hint_reg;
    logic [INDEX_BITS:0] nfree_reg;

    // Read port A: block b; port B: block b-1 for the data start.
    blk_t addr_a, addr_b;
    logic [2*INDEX_BITS-1:0] rd_a_reg, rd_b_reg;
    logic zero_b_reg;

    cnt_t lo_reg, hi_reg, nf_reg;
    cnt_t mid;

    status_t res_status_reg;
    idx_t    res_data_reg;
    blk_t    res_blk_reg, res_lblk_reg;

    idx_t start_a, cend_a, dstart_a, off_a;
    logic hit_a;
    idx_t tgt;
    logic [INDEX_BITS:0] run_end;
    idx_t blast;

    // Append decisions.
    logic bad_run, merge, full, quick_hold;
    blk_t wr_addr;
    logic [2*INDEX_BITS-1:0] wr_data;
    idx_t last_cend;

    cnt_t fb_val;
    logic quick_hold_exec;

    assign mid = cnt_t'((lo_reg + hi_reg) >> 1);
    assign tgt = (cmd.tgt == TGT_LAST) ? last_reg : x_reg;

    always_comb
    begin
        addr_a = hint_reg;
        // The load cycle fetches the last block so an append can extend it.
        if (cmd.load)
            addr_a = blk_t'(count_reg - 1'b1);
        else if (cmd.rd_hint)
            addr_a = hint_reg;
        else if (cmd.chk_hint)
            addr_a = blk_t'(hint_reg + 1'b1);
        else if (cmd.bs_rd)
            addr_a = mid[BLK_BITS-1:0];
        else if (cmd.fin_rd)
        begin
            // For ranges the final read must fetch the first-index block, nf-1.
            if (act_reg == ACT_RANGE)
                addr_a = (nf_reg == '0) ? '0 : blk_t'(nf_reg - 1'b1);
            else
                addr_a = (lo_reg == '0) ? '0 : blk_t'(lo_reg - 1'b1);
        end
        addr_b = blk_t'(addr_a - 1'b1);
    end

    always_ff @(posedge clk)
    begin
        rd_a_reg <= mem[addr_a];
        rd_b_reg <= mem[addr_b];
        if (cmd.exec && act_reg == ACT_APPEND && !quick_hold)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            zero_b_reg <= 1'b0;
        else
            zero_b_reg <= (addr_a == '0);
    end

    // Row check of the block last read.
    assign start_a  = rd_a_reg[2*INDEX_BITS-1:INDEX_BITS];
    assign cend_a   = rd_a_reg[INDEX_BITS-1:0];
    assign dstart_a = zero_b_reg ? '0 : rd_b_reg[INDEX_BITS-1:0];
    assign off_a    = x_reg - start_a;
    assign blast    = start_a + (cend_a - dstart_a) - 1'b1;
    assign hit_a    = (x_reg >= start_a) && (off_a < (cend_a - dstart_a));

    assign run_end   = {1'b0, x_reg} + {1'b0, len_reg};
    assign bad_run   = (len_reg == '0) || ({1'b0, x_reg} < nfree_reg)
                       || (len_reg > ~x_reg);
    assign merge     = (count_reg != '0) && ({1'b0, x_reg} == nfree_reg);
    assign full      = (count_reg == cnt_t'(MAX_BLOCKS));
    assign quick_hold = bad_run || (!merge && full);
    assign last_cend = rd_a_reg[INDEX_BITS-1:0];
    assign wr_addr   = merge ? blk_t'(count_reg - 1'b1) : count_reg[BLK_BITS-1:0];
    assign wr_data   = merge ? {rd_a_reg[2*INDEX_BITS-1:INDEX_BITS], last_cend + len_reg}
                             : {x_reg, ((count_reg == '0) ? '0 : last_cend) + len_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            hint_reg       <= '0;
            nfree_reg      <= '0;
            lo_reg         <= '0;
            hi_reg         <= '0;
            nf_reg         <= '0;
            act_reg        <= ACT_CLEAR;
            x_reg          <= '0;
            len_reg        <= '0;
            last_reg       <= '0;
            res_status_reg <= ST_OK;
            res_data_reg   <= '0;
            res_blk_reg    <= '0;
            res_lblk_reg   <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                act_reg        <= action_t'(action);
                x_reg          <= logical_index;
                len_reg        <= run_length;
                last_reg       <= range_last;
                res_status_reg <= ST_OK;
                res_data_reg   <= '0;
                res_blk_reg    <= '0;
                res_lblk_reg   <= '0;
            end
            if (cmd.exec)
            begin
                lo_reg    <= '0;
                hi_reg    <= count_reg;
                unique case (act_reg)
                    ACT_CLEAR:
                    begin
                        count_reg <= '0;
                        hint_reg  <= '0;
                        nfree_reg <= '0;
                    end
                    ACT_APPEND:
                    begin
                        if (bad_run)
                            res_status_reg <= ST_BAD_RUN;
                        else if (!merge && full)
                            res_status_reg <= ST_FULL;
                        else
                        begin
                            nfree_reg   <= run_end;
                            res_blk_reg <= wr_addr;
                            if (!merge)
                                count_reg <= cnt_t'(count_reg + 1'b1);
                        end
                    end
                    ACT_XLATE:
                    begin
                        if (count_reg == '0)
                            res_status_reg <= ST_NOT_MAPPED;
                    end
                    ACT_RANGE:
                    begin
                        if (count_reg == '0)
                            res_status_reg <= ST_NOT_MAPPED;
                        else if (x_reg > last_reg)
                            res_status_reg <= ST_RANGE_MT;
                    end
                    default: ;
                endcase
            end
            if (cmd.chk_hint)
            begin
                if (cnt_t'(hint_reg) < count_reg && hit_a)
                begin
                    res_blk_reg  <= hint_reg;
                    res_data_reg <= dstart_a + off_a;
                end
            end
            if (cmd.chk_next)
            begin
                if (cnt_t'(hint_reg) + 1'b1 < count_reg && hit_a)
                begin
                    hint_reg     <= blk_t'(hint_reg + 1'b1);
                    res_blk_reg  <= blk_t'(hint_reg + 1'b1);
                    res_data_reg <= dstart_a + off_a;
                end
            end
            if (cmd.bs_cmp)
            begin
                if (start_a <= tgt)
                    lo_reg <= cnt_t'(mid + 1'b1);
                else
                    hi_reg <= mid;
            end
            if (cmd.bs_init && cmd.bs_cmp)
            begin
                // First search done: keep its count, restart for the range end.
                nf_reg <= (start_a <= tgt) ? cnt_t'(mid + 1'b1) : lo_reg;
                lo_reg <= '0;
                hi_reg <= count_reg;
            end
            else if (cmd.bs_init)
            begin
                lo_reg <= '0;
                hi_reg <= count_reg;
            end
            if (cmd.fin_chk)
            begin
                if (act_reg == ACT_XLATE)
                begin
                    hint_reg    <= (lo_reg == '0) ? '0 : blk_t'(lo_reg - 1'b1);
                    res_blk_reg <= (lo_reg == '0) ? '0 : blk_t'(lo_reg - 1'b1);
                    if (lo_reg != '0 && hit_a)
                        res_data_reg <= dstart_a + off_a;
                    else
                        res_status_reg <= ST_NOT_MAPPED;
                end
                else
                begin
                    // lo_reg holds the count for the range end here.
                    if (lo_reg == '0 || fb_val > cnt_t'(lo_reg - 1'b1))
                        res_status_reg <= ST_RANGE_MT;
                    else
                    begin
                        res_blk_reg  <= fb_val[BLK_BITS-1:0];
                        res_lblk_reg <= blk_t'(lo_reg - 1'b1);
                    end
                end
            end
        end
    end

    // First block of the range: step past the block below the start when
    // the start lies in the gap after it.
    always_comb
    begin
        if (nf_reg == '0)
            fb_val = '0;
        else if (x_reg > blast)
            fb_val = nf_reg;
        else
            fb_val = cnt_t'(nf_reg - 1'b1);
    end

    always_comb
    begin
        quick_hold_exec = 1'b1;
        if (act_reg == ACT_XLATE && count_reg != '0)
            quick_hold_exec = 1'b0;
        if (act_reg == ACT_RANGE && count_reg != '0 && x_reg <= last_reg)
            quick_hold_exec = 1'b0;
    end

    assign sts.act          = act_reg;
    assign sts.quick        = quick_hold_exec;
    assign sts.hint_hit     = cnt_t'(hint_reg) < count_reg && hit_a;
    assign sts.next_hit     = cnt_t'(hint_reg) + 1'b1 < count_reg && hit_a;
    assign sts.bs_done      = (lo_reg >= hi_reg) ||
                              ((start_a <= tgt) ? (cnt_t'(mid + 1'b1) >= hi_reg)
                                                : (lo_reg >= mid));

    assign status           = res_status_reg;
    assign data_index       = res_data_reg;
    assign block_index      = res_blk_reg;
    assign last_block_index = res_lblk_reg;

endmodule

@@ rtl/core/sparse_index_block_map.sv @@
// ----------------------------------------------------------------------------
// sparse_index_block_map: run-length index map of a sparse mask
// Appends runs, translates logical to packed indices and finds the blocks
// touching a logical range.
// ----------------------------------------------------------------------------
//  channel | signals                                         | dir
//  input   | valid, ready, action, logical_index,            | in
//          | run_length, range_last                          |
//  output  | out_valid, out_ready, status, data_index,       | out
//          | block_index, last_block_index                   |
//
// One item at a time. Clear and append are decided in the exec step; a
// translation tries the hint block, then the next block, and then a binary
// search, which over 256 blocks needs up to nine read and compare steps. A
// range query runs two searches. Reset empties the table at once.
// The result holds until taken by out_ready, and no beat is accepted before.
// ----------------------------------------------------------------------------
module sparse_index_block_map
    import sibm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid,
    output logic        ready,
    input  logic [1:0]  action,
    input  logic [31:0] logical_index,
    input  logic [31:0] run_length,
    input  logic [31:0] range_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [31:0] data_index,
    output logic [7:0]  block_index,
    output logic [7:0]  last_block_index
);

    cmd_t cmd;
    sts_t sts;

    sibm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid),
        .in_ready  (ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    sibm_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .action           (action),
        .logical_index    (logical_index),
        .run_length       (run_length),
        .range_last       (range_last),
        .cmd              (cmd),
        .sts              (sts),
        .status           (status),
        .data_index       (data_index),
        .block_index      (block_index),
        .last_block_index (last_block_index)
    );

endmodule
